// ----- rtl/bounded_shift_list_deque_unit_defines.svh -----
// Assertion macros used by the deque top level.
`ifndef BOUNDED_SHIFT_LIST_DEQUE_UNIT_DEFINES_SVH
`define BOUNDED_SHIFT_LIST_DEQUE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BSLD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSLD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/bsld_pkg.sv -----
// Shared types and codes for the bounded shift-list deque.
package bsld_pkg;

	// Width of the cell select index; covers the largest supported capacity.
	localparam int IDX_W = 10;

	typedef enum logic [2:0] {
		ACT_INS_HEAD = 3'd0,
		ACT_INS_TAIL = 3'd1,
		ACT_RM_HEAD  = 3'd2,
		ACT_RM_TAIL  = 3'd3,
		ACT_RD_HEAD  = 3'd4,
		ACT_RD_TAIL  = 3'd5,
		ACT_RD_INDEX = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Operation broadcast to every cell at once.
	typedef enum logic [2:0] {
		CELL_HOLD = 3'd0,
		CELL_SHR  = 3'd1,
		CELL_SHL  = 3'd2,
		CELL_PUT  = 3'd3,
		CELL_RD   = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [IDX_W-1:0] tgt;
	} cell_cmd_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_READ = 1'b1
	} fsm_state_t;

endpackage

// ----- rtl/bsld_cell.sv -----
// One storage cell of the deque chain with its read-forwarding register.
module bsld_cell import bsld_pkg::*; #(
	parameter int ELEM_WIDTH = 32,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  cell_cmd_t             cmd,
	input  logic [ELEM_WIDTH-1:0] word,
	input  logic [ELEM_WIDTH-1:0] prev_elem,
	input  logic [ELEM_WIDTH-1:0] next_elem,
	input  logic [ELEM_WIDTH-1:0] next_rd,
	output logic [ELEM_WIDTH-1:0] elem,
	output logic [ELEM_WIDTH-1:0] rd
);

	logic [ELEM_WIDTH-1:0] elem_q;
	logic [ELEM_WIDTH-1:0] rd_q;
	logic                  hit;

	// This cell is the one addressed by the command.
	assign hit = (cmd.tgt == IDX_W'(INDEX));

	// Element storage: shift with the neighbors or take a new word.
	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_SHR: elem_q <= prev_elem;
			CELL_SHL: elem_q <= next_elem;
			CELL_PUT: begin
				if (hit) begin
					elem_q <= word;
				end
			end
			default: ;
		endcase
	end

	// Read path: the addressed cell injects its element, others pass it toward the head.
	always_ff @(posedge clk) begin
		if (cmd.op == CELL_RD) begin
			rd_q <= hit ? elem_q : next_rd;
		end
	end

	assign elem = elem_q;
	assign rd   = rd_q;

endmodule

// ----- rtl/bsld_ctrl.sv -----
// Sequencer of the deque: decodes actions, tracks the fill level and holds the result beat.
module bsld_ctrl import bsld_pkg::*; #(
	parameter int CAPACITY   = 256,
	parameter int ELEM_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            action,
	input  logic [7:0]            position,
	input  logic [ELEM_WIDTH-1:0] head_rd,
	output cell_cmd_t             cmd,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [31:0]           elem_out,
	output logic [8:0]            count,
	output logic [1:0]            status
);

	localparam int FW = $clog2(CAPACITY + 1);

	fsm_state_t       state_q, state_d;
	logic [FW-1:0]    fill_q, fill_d;
	logic [IDX_W-1:0] tgt_q, cnt_q;
	logic             out_valid_q;
	logic [31:0]      elem_out_q;
	logic [8:0]       count_q;
	status_t          status_q, status_d;
	action_t          act;
	cell_op_t         dec_op;
	logic [IDX_W-1:0] dec_tgt;
	logic             rd_go;
	logic             accept;
	logic             full, empty;
	logic             read_done;
	logic             load_out;

	assign act       = action_t'(action);
	assign full      = (fill_q == FW'(CAPACITY));
	assign empty     = (fill_q == '0);
	assign accept    = in_valid && in_ready;
	assign read_done = (state_q == S_READ) && (cnt_q == '0);
	assign load_out  = (accept && !rd_go) || read_done;

	// Action decode against the current fill level.
	always_comb begin
		fill_d   = fill_q;
		status_d = ST_OK;
		dec_op   = CELL_HOLD;
		dec_tgt  = '0;
		rd_go    = 1'b0;
		case (act)
			ACT_INS_HEAD: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					fill_d = fill_q + 1'b1;
					dec_op = CELL_SHR;
				end
			end
			ACT_INS_TAIL: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					fill_d  = fill_q + 1'b1;
					dec_op  = CELL_PUT;
					dec_tgt = IDX_W'(fill_q);
				end
			end
			ACT_RM_HEAD: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					fill_d = fill_q - 1'b1;
					dec_op = CELL_SHL;
				end
			end
			ACT_RM_TAIL: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					fill_d = fill_q - 1'b1;
				end
			end
			ACT_RD_HEAD: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_go  = 1'b1;
					dec_op = CELL_RD;
				end
			end
			ACT_RD_TAIL: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_go   = 1'b1;
					dec_op  = CELL_RD;
					dec_tgt = IDX_W'(fill_q - 1'b1);
				end
			end
			ACT_RD_INDEX: begin
				if (32'(position) >= 32'(fill_q)) begin
					status_d = ST_RANGE;
				end else begin
					rd_go   = 1'b1;
					dec_op  = CELL_RD;
					dec_tgt = IDX_W'(position);
				end
			end
			default: ;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && rd_go) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (cnt_q == '0) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State outputs: input handshake and the command broadcast to the cells.
	always_comb begin
		in_ready = 1'b0;
		cmd.op   = CELL_HOLD;
		cmd.tgt  = tgt_q;
		case (state_q)
			S_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				cmd.op   = accept ? dec_op : CELL_HOLD;
				cmd.tgt  = dec_tgt;
			end
			S_READ: begin
				cmd.op  = (cnt_q == '0) ? CELL_HOLD : CELL_RD;
				cmd.tgt = tgt_q;
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				fill_q <= fill_d;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Read walk and result beat payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_q      <= dec_tgt;
			cnt_q      <= dec_tgt;
			count_q    <= 9'(fill_d);
			status_q   <= status_d;
			elem_out_q <= '0;
		end else if (state_q == S_READ) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				elem_out_q <= 32'(head_rd);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign elem_out  = elem_out_q;
	assign count     = count_q;
	assign status    = status_q;

endmodule

// ----- rtl/bounded_shift_list_deque_unit.sv -----
// Bounded shift-list deque: sequencer plus a chain of element cells.
// Insert, remove, failed and unused actions: result beat in the cycle after acceptance.
// A successful read of entry k (head is 0): the read path walks the element one cell per cycle
// from cell k toward the head of the chain, and the result register then takes it.
// A new beat is taken once the sequencer is idle and the result register is free.
// Reset clears the fill level and handshake state; cell contents stay undefined.
`include "bounded_shift_list_deque_unit_defines.svh"

module bounded_shift_list_deque_unit import bsld_pkg::*; #(
	parameter int CAPACITY   = 256,
	parameter int ELEM_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [31:0] elem_in,
	input  logic [7:0]  position,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] elem_out,
	output logic [8:0]  count,
	output logic [1:0]  status
);

	cell_cmd_t             cmd;
	logic [ELEM_WIDTH-1:0] word;
	logic [ELEM_WIDTH-1:0] elem_w [CAPACITY];
	logic [ELEM_WIDTH-1:0] rd_w   [CAPACITY];

	assign word = ELEM_WIDTH'(elem_in);

	// Sequencer.
	bsld_ctrl #(
		.CAPACITY   (CAPACITY),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.position  (position),
		.head_rd   (rd_w[0]),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.elem_out  (elem_out),
		.count     (count),
		.status    (status)
	);

	// Cell chain; the head cell takes the new word on a head insert.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ELEM_WIDTH-1:0] prev_e, next_e, next_r;
		if (i == 0) begin : g_head
			assign prev_e = word;
		end else begin : g_mid
			assign prev_e = elem_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign next_e = elem_w[i];
			assign next_r = rd_w[i];
		end else begin : g_body
			assign next_e = elem_w[i+1];
			assign next_r = rd_w[i+1];
		end
		bsld_cell #(
			.ELEM_WIDTH (ELEM_WIDTH),
			.INDEX      (i)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.word      (word),
			.prev_elem (prev_e),
			.next_elem (next_e),
			.next_rd   (next_r),
			.elem      (elem_w[i]),
			.rd        (rd_w[i])
		);
	end

	// A refused insert means the list is at capacity; a refused remove means it is empty.
	`BSLD_ASSERT_NOW(a_full_count, out_valid && (status == ST_FULL), count == 9'(CAPACITY), "full status with count below capacity")
	`BSLD_ASSERT_NOW(a_empty_count, out_valid && (status == ST_EMPTY), count == 9'd0, "empty status with nonzero count")
	// After a beat is taken, either a result is pending or the read walk blocks the input.
	`BSLD_ASSERT_NEXT(a_accept_follow, in_valid && in_ready, out_valid || !in_ready, "accepted beat left no trace")

endmodule

// ----- tb/bounded_shift_list_deque_unit_checker.sv -----
// Checker for the deque unit: watches both channels, predicts each result and compares it.
module bounded_shift_list_deque_unit_checker import bsld_pkg::*; #(
	parameter int CAPACITY = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  action,
	input  logic [31:0] elem_in,
	input  logic [7:0]  position,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] elem_out,
	input  logic [8:0]  count,
	input  logic [1:0]  status,
	output int          mismatches,
	output int          outstanding,
	output int          level
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] elem;
		logic [8:0]  size;
		status_t     code;
	} deque_reply_t;

	// Shadow copy of the list and its size.
	logic [31:0] shadow_cells [CAPACITY];
	int          shadow_fill = 0;

	deque_reply_t due_replies [$];
	int           mismatch_total = 0;

	assign mismatches = mismatch_total;

	initial begin
		outstanding = 0;
		level = 0;
	end

	// Print one line per mismatch and count it.
	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_total++;
	endtask

	// Apply one action to the shadow list and work out the reply it causes.
	task automatic shadow_list_step(input logic [2:0] act, input logic [31:0] word,
			input logic [7:0] pos, output deque_reply_t reply);
		logic [31:0] data;
		status_t     code;
		data = '0;
		code = ST_OK;
		case (act)
			ACT_INS_HEAD: begin
				if (shadow_fill >= CAPACITY) begin
					code = ST_FULL;
				end else begin
					for (int i = shadow_fill; i > 0; i--)
						shadow_cells[i] = shadow_cells[i-1];
					shadow_cells[0] = word;
					shadow_fill++;
				end
			end
			ACT_INS_TAIL: begin
				if (shadow_fill >= CAPACITY) begin
					code = ST_FULL;
				end else begin
					shadow_cells[shadow_fill] = word;
					shadow_fill++;
				end
			end
			ACT_RM_HEAD: begin
				if (shadow_fill == 0) begin
					code = ST_EMPTY;
				end else begin
					for (int i = 0; i + 1 < shadow_fill; i++)
						shadow_cells[i] = shadow_cells[i+1];
					shadow_fill--;
				end
			end
			ACT_RM_TAIL: begin
				if (shadow_fill == 0)
					code = ST_EMPTY;
				else
					shadow_fill--;
			end
			ACT_RD_HEAD: begin
				if (shadow_fill == 0)
					code = ST_EMPTY;
				else
					data = shadow_cells[0];
			end
			ACT_RD_TAIL: begin
				if (shadow_fill == 0)
					code = ST_EMPTY;
				else
					data = shadow_cells[shadow_fill-1];
			end
			ACT_RD_INDEX: begin
				if (int'(pos) >= shadow_fill || int'(pos) >= CAPACITY)
					code = ST_RANGE;
				else
					data = shadow_cells[pos];
			end
			// The unused code leaves the list alone and reports success.
			default: begin
			end
		endcase
		reply.elem = data;
		reply.size = 9'(shadow_fill);
		reply.code = code;
	endtask

	// Results are retired before new inputs, since a beat never comes back in its own cycle.
	always @(posedge clk) begin : watch
		deque_reply_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (due_replies.size() == 0) begin
					report_mismatch($sformatf("result beat with nothing pending: elem 0x%0h count %0d status %0d",
						elem_out, count, status));
				end else begin
					want = due_replies.pop_front();
					if (elem_out !== want.elem)
						report_mismatch($sformatf("elem_out got 0x%0h, want 0x%0h",
							elem_out, want.elem));
					if (count !== want.size)
						report_mismatch($sformatf("count got %0d, want %0d", count, want.size));
					if (status !== want.code)
						report_mismatch($sformatf("status got %0d, want %0d", status, want.code));
				end
			end
			if (in_valid && in_ready) begin
				shadow_list_step(action, elem_in, position, want);
				due_replies.push_back(want);
			end
		end
		outstanding <= due_replies.size();
		level <= shadow_fill;
	end

endmodule

// ----- tb/bounded_shift_list_deque_unit_test.sv -----
// Testbench top for the deque unit: clock, reset, stimulus, receiver stalls and verdict.
module bounded_shift_list_deque_unit_test import bsld_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY        = 256;
	localparam int RANDOM_BEATS    = 750;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int HOLD_OFF_AFTER  = 120;
	localparam int IDLE_LIMIT      = 6000;
	localparam int DRAIN_CYCLES    = 300;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [2:0]  action    = '0;
	logic [31:0] elem_in   = '0;
	logic [7:0]  position  = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] elem_out;
	logic [8:0]  count;
	logic [1:0]  status;

	int mismatches;
	int outstanding;
	int level;
	int beats_sent = 0;
	bit no_idle    = 1'b0;

	bounded_shift_list_deque_unit #(
		.CAPACITY  (CAPACITY),
		.ELEM_WIDTH(32)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.elem_in  (elem_in),
		.position (position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.elem_out (elem_out),
		.count    (count),
		.status   (status)
	);

	bounded_shift_list_deque_unit_checker #(
		.CAPACITY(CAPACITY)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.elem_in    (elem_in),
		.position   (position),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.elem_out   (elem_out),
		.count      (count),
		.status     (status),
		.mismatches (mismatches),
		.outstanding(outstanding),
		.level      (level)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Idle cycles before an input beat: mostly none or short, now and then long.
	function automatic int input_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Element words with the all-zero and all-one extremes mixed in.
	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		else if (r == 1)
			return '1;
		else
			return $urandom;
	endfunction

	// Index reads: mostly in range, some near the fill boundary, some anywhere.
	function automatic logic [7:0] pick_index(input int lvl);
		int r;
		r = $urandom_range(0, 3);
		if (r == 0)
			return 8'($urandom_range(0, 255));
		else if (r == 3)
			return 8'(lvl + $urandom_range(0, 2) - 1 > 255 ? 255 :
				(lvl + $urandom_range(0, 2) - 1 < 0 ? 0 : lvl + $urandom_range(0, 2) - 1));
		else if (lvl > 0)
			return 8'($urandom_range(0, lvl - 1));
		else
			return '0;
	endfunction

	// Offer one input beat after a random gap and hold it until it is taken.
	task automatic send_beat(input logic [2:0] act, input logic [31:0] word,
			input logic [7:0] pos);
		int gap;
		gap = input_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		elem_in  <= word;
		position <= pos;
		do
			@(posedge clk);
		while (!in_ready);
		beats_sent <= beats_sent + 1;
	endtask

	// Stimulus: reset, a directed pass, then a level-steered random pass.
	initial begin : stimulus
		int          lvl;
		int          target;
		int          dwell;
		int          r;
		bit          grow;
		logic [2:0]  act;
		logic [7:0]  pos;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty-list errors, then a few entries with extreme words and reads on them, then removals back to empty.
		send_beat(ACT_RD_HEAD, 32'hDEAD_BEEF, 8'd0);
		send_beat(ACT_RD_TAIL, 32'h0, 8'd255);
		send_beat(ACT_RD_INDEX, 32'h0, 8'd0);
		send_beat(ACT_RD_INDEX, 32'hFFFF_FFFF, 8'd255);
		send_beat(ACT_RM_HEAD, 32'h0, 8'd0);
		send_beat(ACT_RM_TAIL, 32'h1234_5678, 8'd7);
		send_beat(ACT_INS_HEAD, 32'hFFFF_FFFF, 8'd0);
		send_beat(ACT_INS_TAIL, 32'h0000_0000, 8'd255);
		send_beat(ACT_INS_HEAD, 32'hA5A5_5A5A, 8'd0);
		send_beat(ACT_INS_TAIL, 32'h8000_0001, 8'd0);
		send_beat(ACT_RD_HEAD, 32'h0, 8'd0);
		send_beat(ACT_RD_TAIL, 32'h0, 8'd0);
		send_beat(ACT_RD_INDEX, 32'h0, 8'd0);
		send_beat(ACT_RD_INDEX, 32'h0, 8'd1);
		send_beat(ACT_RD_INDEX, 32'h0, 8'd3);
		send_beat(ACT_RD_INDEX, 32'h0, 8'd4);
		send_beat(ACT_RD_INDEX, 32'h0, 8'd255);
		send_beat(ACT_RM_HEAD, 32'h0, 8'd0);
		send_beat(ACT_RD_HEAD, 32'h0, 8'd0);
		send_beat(ACT_RM_TAIL, 32'h0, 8'd0);
		send_beat(ACT_RD_TAIL, 32'h0, 8'd0);
		send_beat(ACT_RM_HEAD, 32'h0, 8'd0);
		send_beat(ACT_RM_TAIL, 32'h0, 8'd0);
		send_beat(ACT_RD_INDEX, 32'h0, 8'd0);

		// Random pass: steer the level toward a target, fill and drain completely first.
		target = CAPACITY;
		dwell  = 0;
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 30 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			lvl = level;
			if (dwell == 0 && lvl == target)
				dwell = $urandom_range(10, 25);
			if (dwell > 0) begin
				dwell--;
				if (dwell == 0) begin
					if (target == CAPACITY)
						target = 0;
					else if (target == 0)
						target = ($urandom_range(0, 2) == 0) ? CAPACITY :
							$urandom_range(1, CAPACITY - 1);
					else
						target = $urandom_range(0, CAPACITY);
				end
				grow = $urandom_range(0, 1);
			end else begin
				grow = (lvl < target);
			end
			pos = 8'($urandom_range(0, 255));
			r = $urandom_range(0, 99);
			if (r < 16) begin
				case ($urandom_range(0, 2))
					0: act = ACT_RD_HEAD;
					1: act = ACT_RD_TAIL;
					default: begin
						act = ACT_RD_INDEX;
						pos = pick_index(lvl);
					end
				endcase
			end else if (grow ? ($urandom_range(0, 99) < 92) : ($urandom_range(0, 99) < 8)) begin
				act = $urandom_range(0, 1) ? ACT_INS_HEAD : ACT_INS_TAIL;
			end else begin
				act = $urandom_range(0, 1) ? ACT_RM_HEAD : ACT_RM_TAIL;
			end
			send_beat(act, pick_word(), pos);
		end

		// Drain: wait for every pending result, then let the block settle.
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("bounded_shift_list_deque_unit_test passed");
		else
			$display("bounded_shift_list_deque_unit_test failed");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off so the block backs up.
	initial begin : receiver
		int  r;
		int  span;
		bit  held_off;
		held_off = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_off && beats_sent >= HOLD_OFF_AFTER) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					out_ready <= 1'b1;
					span = $urandom_range(1, 30);
				end else if (r < 92) begin
					out_ready <= 1'b0;
					span = $urandom_range(1, 3);
				end else begin
					out_ready <= 1'b0;
					span = $urandom_range(8, 60);
				end
				repeat (span) @(posedge clk);
			end
		end
	end

	// Watchdog: end the run if no beat moves on either channel for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[%0t] watchdog: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
		$display("bounded_shift_list_deque_unit_test failed");
		$finish;
	end

endmodule
